// ----- hw/rtl/lbps_pkg.sv -----
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared types and constants for the LED burst pattern sequencer.
// ----------------------------------------------------------------------------
package lbps_pkg;

  localparam int unsigned DurW   = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    PH_SLOW_ON  = 3'd0,
    PH_SLOW_OFF = 3'd1,
    PH_FAST_ON  = 3'd2,
    PH_FAST_OFF = 3'd3,
    PH_PAUSE    = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOW_HALF  = 3'd0,
    REG_FAST_HALF  = 3'd1,
    REG_PAUSE_LEN  = 3'd2,
    REG_SLOW_TOTAL = 3'd3,
    REG_FAST_TOTAL = 3'd4
  } cfg_reg_e;

  localparam logic [DurW-1:0]   SlowHalfRst  = 16'd500;
  localparam logic [DurW-1:0]   FastHalfRst  = 16'd150;
  localparam logic [DurW-1:0]   PauseLenRst  = 16'd2000;
  localparam logic [CountW-1:0] SlowTotalRst = 8'd3;
  localparam logic [CountW-1:0] FastTotalRst = 8'd5;

  typedef struct packed {
    logic [DurW-1:0]   slow_half;
    logic [DurW-1:0]   fast_half;
    logic [DurW-1:0]   pause_len;
    logic [CountW-1:0] slow_total;
    logic [CountW-1:0] fast_total;
  } cfg_t;

  typedef struct packed {
    logic   phase_changed;
    phase_e phase;
    logic   led_on;
  } res_t;

endpackage

// ----- hw/rtl/lbps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lbps_cfg_regs
// Configuration register file: durations and pulse totals.
// ----------------------------------------------------------------------------
module lbps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lbps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lbps_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output lbps_pkg::cfg_t                 cfg_o
);
  import lbps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLOW_HALF:  cfg_d.slow_half  = cfg_wdata_i[DurW-1:0];
        REG_FAST_HALF:  cfg_d.fast_half  = cfg_wdata_i[DurW-1:0];
        REG_PAUSE_LEN:  cfg_d.pause_len  = cfg_wdata_i[DurW-1:0];
        REG_SLOW_TOTAL: cfg_d.slow_total = cfg_wdata_i[CountW-1:0];
        REG_FAST_TOTAL: cfg_d.fast_total = cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_half  <= SlowHalfRst;
      cfg_q.fast_half  <= FastHalfRst;
      cfg_q.pause_len  <= PauseLenRst;
      cfg_q.slow_total <= SlowTotalRst;
      cfg_q.fast_total <= FastTotalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/lbps_fsm.sv -----
// ----------------------------------------------------------------------------
// lbps_fsm
// Phase state machine with phase timer and slow/fast pulse counters.
// ----------------------------------------------------------------------------
module lbps_fsm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           advance_i,
  input  lbps_pkg::cfg_t cfg_i,
  output lbps_pkg::res_t res_o
);
  import lbps_pkg::*;

  phase_e            phase_q, phase_d;
  logic [DurW-1:0]   elapsed_q, elapsed_d;
  logic [CountW-1:0] slow_cnt_q, slow_cnt_d;
  logic [CountW-1:0] fast_cnt_q, fast_cnt_d;
  logic [DurW-1:0]   elapsed_inc;
  logic [CountW:0]   slow_next, fast_next;
  logic              changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SLOW_ON;
      elapsed_q  <= '0;
      slow_cnt_q <= '0;
      fast_cnt_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      slow_cnt_q <= slow_cnt_d;
      fast_cnt_q <= fast_cnt_d;
    end
  end

  always_comb begin
    elapsed_inc = elapsed_q;
    if (advance_i && (elapsed_q != '1)) begin
      elapsed_inc = elapsed_q + 1'b1;
    end
    slow_next  = {1'b0, slow_cnt_q} + 1'b1;
    fast_next  = {1'b0, fast_cnt_q} + 1'b1;
    phase_d    = phase_q;
    elapsed_d  = elapsed_inc;
    slow_cnt_d = slow_cnt_q;
    fast_cnt_d = fast_cnt_q;
    changed    = 1'b0;
    case (phase_q)
      PH_SLOW_ON: begin
        if (elapsed_inc >= cfg_i.slow_half) begin
          phase_d = PH_SLOW_OFF;
          changed = 1'b1;
        end
      end
      PH_SLOW_OFF: begin
        if (elapsed_inc >= cfg_i.slow_half) begin
          changed = 1'b1;
          if (slow_next >= {1'b0, cfg_i.slow_total}) begin
            slow_cnt_d = '0;
            phase_d    = PH_FAST_ON;
          end else begin
            slow_cnt_d = slow_next[CountW-1:0];
            phase_d    = PH_SLOW_ON;
          end
        end
      end
      PH_FAST_ON: begin
        if (elapsed_inc >= cfg_i.fast_half) begin
          phase_d = PH_FAST_OFF;
          changed = 1'b1;
        end
      end
      PH_FAST_OFF: begin
        if (elapsed_inc >= cfg_i.fast_half) begin
          changed = 1'b1;
          if (fast_next >= {1'b0, cfg_i.fast_total}) begin
            fast_cnt_d = '0;
            phase_d    = PH_PAUSE;
          end else begin
            fast_cnt_d = fast_next[CountW-1:0];
            phase_d    = PH_FAST_ON;
          end
        end
      end
      PH_PAUSE: begin
        if (elapsed_inc >= cfg_i.pause_len) begin
          phase_d = PH_SLOW_ON;
          changed = 1'b1;
        end
      end
      default: begin
        slow_cnt_d = '0;
        fast_cnt_d = '0;
        phase_d    = PH_PAUSE;
        changed    = 1'b1;
      end
    endcase
    if (changed) begin
      elapsed_d = '0;
    end
    res_o.phase         = phase_d;
    res_o.phase_changed = changed;
    res_o.led_on        = (phase_d == PH_SLOW_ON) || (phase_d == PH_FAST_ON);
  end

  // Assertions
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(elapsed_q))
    else $error("state moved without a beat");

  a_clear_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && changed |=> elapsed_q == '0)
    else $error("timer not cleared on phase change");

  a_keep_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !changed |=> phase_q == $past(phase_q))
    else $error("phase changed without flag");

endmodule

// ----- hw/rtl/led_burst_pattern_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// led_burst_pattern_sequencer_core
// LED burst pattern sequencer: slow pulses, fast pulses, dark pause.
// ----------------------------------------------------------------------------
// One poll beat is accepted per clock cycle while the core is not stalled. A beat
// is captured in an input register; when the output register is free, the phase
// machine updates its timer, counters and phase and the result beat is registered
// in the output register in the same step. Throughput is one beat per cycle while
// the master side accepts.
module led_burst_pattern_sequencer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [0] advance
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [0] led_on, [3:1] phase,
                                                        // [4] phase_changed
  input  logic                           cfg_we_i,
  input  logic [lbps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lbps_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import lbps_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_q;
  logic in_valid_q, out_valid_q;
  logic in_adv_q;
  logic out_free, step;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_adv_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_q <= res;
    end
  end

  lbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lbps_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .advance_i (in_adv_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.phase_changed, out_q.phase, out_q.led_on};

  // Assertions
  a_led_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.led_on ==
      ((out_q.phase == PH_SLOW_ON) || (out_q.phase == PH_FAST_ON)))
    else $error("LED level disagrees with phase");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_q))
    else $error("result beat lost under stall");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_adv_q))
    else $error("input beat lost under stall");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the LED burst pattern sequencer core.
// ----------------------------------------------------------------------------
// Poll beats come from a queue and go out on the slave stream. Each accepted
// beat is run through a local copy of the phase machine, and the expected
// result is queued. Result beats on the master stream are checked field by
// field against that queue. Both streams idle at random. Timing and pulse
// registers are rewritten between phases while the core is idle. Settings
// include zero durations and totals, totals of 255, lowered totals, ignored
// register indexes, and the longest durations.
// ----------------------------------------------------------------------------
module tb_top;
  import lbps_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 4;
  localparam int unsigned PhaseBeats = 150;
  localparam int unsigned NumPhases  = 13;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [0] advance
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [0] led_on, [3:1] phase, [4] phase_changed
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // pending polls and expected LED results
  logic poll_q[$];
  res_t led_q[$];
  int   sent_beats = 0;
  int   taken_beats = 0;
  int   cycles = 0;
  int   errors = 0;
  logic quiet = 1'b0;

  // local phase machine
  cfg_t        cfg_m;
  phase_e      cur_phase;
  logic [15:0] phase_ms;
  logic [7:0]  slow_pulses;
  logic [7:0]  fast_pulses;

  led_burst_pattern_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic idle_now();
    return !quiet && ($urandom_range(99) < 6);
  endfunction

  function automatic res_t step_pattern(logic tick);
    res_t       r;
    logic       moved;
    logic [8:0] nxt;
    moved = 1'b0;
    if (tick && phase_ms != 16'hFFFF) phase_ms = phase_ms + 16'd1;
    case (cur_phase)
      PH_SLOW_ON: begin
        if (phase_ms >= cfg_m.slow_half) begin
          cur_phase = PH_SLOW_OFF;
          moved = 1'b1;
        end
      end
      PH_SLOW_OFF: begin
        if (phase_ms >= cfg_m.slow_half) begin
          nxt = {1'b0, slow_pulses} + 9'd1;
          if (nxt >= {1'b0, cfg_m.slow_total}) begin
            slow_pulses = '0;
            cur_phase = PH_FAST_ON;
          end else begin
            slow_pulses = nxt[7:0];
            cur_phase = PH_SLOW_ON;
          end
          moved = 1'b1;
        end
      end
      PH_FAST_ON: begin
        if (phase_ms >= cfg_m.fast_half) begin
          cur_phase = PH_FAST_OFF;
          moved = 1'b1;
        end
      end
      PH_FAST_OFF: begin
        if (phase_ms >= cfg_m.fast_half) begin
          nxt = {1'b0, fast_pulses} + 9'd1;
          if (nxt >= {1'b0, cfg_m.fast_total}) begin
            fast_pulses = '0;
            cur_phase = PH_PAUSE;
          end else begin
            fast_pulses = nxt[7:0];
            cur_phase = PH_FAST_ON;
          end
          moved = 1'b1;
        end
      end
      PH_PAUSE: begin
        if (phase_ms >= cfg_m.pause_len) begin
          cur_phase = PH_SLOW_ON;
          moved = 1'b1;
        end
      end
      default: begin
        slow_pulses = '0;
        fast_pulses = '0;
        cur_phase = PH_PAUSE;
        moved = 1'b1;
      end
    endcase
    if (moved) phase_ms = '0;
    r.led_on        = (cur_phase == PH_SLOW_ON) || (cur_phase == PH_FAST_ON);
    r.phase         = cur_phase;
    r.phase_changed = moved;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR @%0t beat %0d: %s got %0d expected %0d", $realtime, taken_beats,
             what, got, want);
    errors++;
  endtask

  // slave-side driver
  always @(negedge clk_i) begin
    if (rst_ni && sent_beats == taken_beats) begin
      if (poll_q.size() != 0 && !idle_now()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, poll_q.pop_front()};
        sent_beats    <= sent_beats + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !idle_now();
  end

  // monitor and checker
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[4:0]);
        if (led_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, tdata", m_axis_tdata, 0);
        end else begin
          want = led_q.pop_front();
          if (got.led_on !== want.led_on)
            report_mismatch("led_on", got.led_on, want.led_on);
          if (got.phase !== want.phase)
            report_mismatch("phase", got.phase, want.phase);
          if (got.phase_changed !== want.phase_changed)
            report_mismatch("phase_changed", got.phase_changed, want.phase_changed);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        led_q.push_back(step_pattern(s_axis_tdata[0]));
        taken_beats <= taken_beats + 1;
      end
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_SLOW_HALF:  cfg_m.slow_half  = data;
      REG_FAST_HALF:  cfg_m.fast_half  = data;
      REG_PAUSE_LEN:  cfg_m.pause_len  = data;
      REG_SLOW_TOTAL: cfg_m.slow_total = data[CountW-1:0];
      REG_FAST_TOTAL: cfg_m.fast_total = data[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_pattern(logic [15:0] sh, logic [15:0] fh, logic [15:0] pl,
                             logic [15:0] st, logic [15:0] ft);
    write_reg(REG_SLOW_HALF, sh);
    write_reg(REG_FAST_HALF, fh);
    write_reg(REG_PAUSE_LEN, pl);
    write_reg(REG_SLOW_TOTAL, st);
    write_reg(REG_FAST_TOTAL, ft);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (poll_q.size() != 0 || sent_beats != taken_beats || led_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic add_polls(int n, int tick_pct);
    for (int i = 0; i < n; i++) poll_q.push_back($urandom_range(99) < tick_pct);
  endtask

  function automatic logic [15:0] pick_half();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    return 16'($urandom_range(1, 8));
  endfunction

  function automatic logic [15:0] pick_total();
    int unsigned r;
    logic [7:0]  junk;
    r = $urandom_range(99);
    junk = 8'($urandom);
    if (r < 10) return {junk, 8'd0};
    if (r < 20) return {junk, 8'd255};
    return {junk, 8'($urandom_range(1, 6))};
  endfunction

  initial begin
    cfg_m       = '{SlowHalfRst, FastHalfRst, PauseLenRst, SlowTotalRst, FastTotalRst};
    cur_phase   = PH_SLOW_ON;
    phase_ms    = '0;
    slow_pulses = '0;
    fast_pulses = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: nothing moves yet
    poll_q.push_back(1'b0);
    poll_q.push_back(1'b1);
    wait_drained();

    // short timings; unused indexes must be ignored
    for (int i = int'(REG_FAST_TOTAL) + 1; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), 16'($urandom));
    set_pattern(16'd1, 16'd1, 16'd2, 16'd1, 16'hA502);
    for (int i = 0; i < 8; i++) poll_q.push_back(i % 3 != 2);
    wait_drained();

    // zero durations and totals: a change on every beat
    set_pattern(16'd0, 16'd0, 16'd0, 16'h0000, 16'hFF00);
    repeat (5) poll_q.push_back(1'b0);
    wait_drained();

    // let counts grow, then lower the totals under them
    set_pattern(16'd0, 16'd0, 16'd0, 16'd200, 16'd200);
    repeat (6) poll_q.push_back(1'b0);
    wait_drained();
    set_pattern(16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
    repeat (4) poll_q.push_back(1'b1);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      quiet = (p == 6);
      if (p == 0)
        set_pattern(16'd0, 16'd0, 16'd1, 16'd255, 16'd255);
      else
        set_pattern(pick_half(), pick_half(), pick_half(), pick_total(), pick_total());
      add_polls(PhaseBeats, 85);
      wait_drained();
    end
    quiet = 1'b0;

    // longest durations
    set_pattern(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2, 16'd2);
    add_polls(20, 50);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (led_q.size() != 0) report_mismatch("results left over", led_q.size(), 0);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lbps_pkg.sv
hw/rtl/lbps_cfg_regs.sv
hw/rtl/lbps_fsm.sv
hw/rtl/led_burst_pattern_sequencer_core.sv
bench/tb_top.sv
